// File: hdl/pgd_pkg.sv
package pgd_pkg;

  localparam int UniformBits = 32;
  localparam int OutFracBits = 26;
  localparam int OutBits     = 32;
  localparam int LogBits     = 56;
  localparam int DivSteps    = 62;
  localparam int SqrtSteps   = 32;
  // right shift that takes |a|*sqrt(r) to the output scale, before the exponent
  localparam int ShiftBias   = 31 + UniformBits - OutFracBits;
  // round(2*ln(2) * 2^62)
  localparam logic [62:0] TwoLn2Q62 = 63'h58B90BFBE8E7BCD6;

  typedef struct packed {
    logic [UniformBits-1:0] mag0;
    logic [UniformBits-1:0] mag1;
    logic                   neg0;
    logic                   neg1;
  } pair_t;

  typedef struct packed {
    pair_t       pair;
    logic [62:0] m;
    logic [6:0]  q;
  } front_t;

  typedef struct packed {
    pair_t              pair;
    logic [62:0]        m;
    logic [62:0]        qm;
    logic signed [7:0]  e;
  } quot_in_t;

  typedef struct packed {
    pair_t              pair;
    logic [62:0]        r;
    logic signed [7:0]  e;
  } root_in_t;

  typedef struct packed {
    pair_t       pair;
    logic [31:0] s;
    logic [6:0]  rsh;
  } scale_in_t;

  // Count leading zeros of a 64-bit word by halving; zero input gives 63.
  function automatic logic [5:0] lzc64(input logic [63:0] v);
    logic [63:0] x;
    logic [5:0]  n;
    x = v;
    n = '0;
    for (int i = 5; i >= 0; i--) begin
      if ((x >> (64 - (1 << i))) == 64'd0) begin
        n = n | 6'(1 << i);
        x = x << (1 << i);
      end
    end
    return n;
  endfunction

endpackage

// File: hdl/pgd_if.sv
interface pgd_in_if;
  import pgd_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [UniformBits-1:0] uniform_first;
  logic [UniformBits-1:0] uniform_second;
  modport source (output valid, uniform_first, uniform_second, input ready);
  modport sink (input valid, uniform_first, uniform_second, output ready);
endinterface

interface pgd_out_if;
  import pgd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [OutBits-1:0] deviate;
  logic                      last_of_pair;
  modport source (output valid, deviate, last_of_pair, input ready);
  modport sink (input valid, deviate, last_of_pair, output ready);
endinterface

// File: hdl/polar_gaussian_deviate.sv
// Pipeline: normalize, log2 iterations and tail, divide, square root, scale,
//   and the output slot, in that order.
// Throughput: a pair enters every cycle while the output slot is empty;
//   each accepted pair leaves as two deviate transfers while the pipeline waits.
// Rejected pairs leave no result. Reset (rst_ni low) clears all valid bits.
module polar_gaussian_deviate (
  input  logic      clk_i,
  input  logic      rst_ni,
  pgd_in_if.sink    in_i,
  pgd_out_if.source out_o
);
  import pgd_pkg::*;

  logic      en;
  logic      fr_v, lg_v, dv_v, sq_v;
  front_t    fr_d;
  quot_in_t  lg_d;
  root_in_t  dv_d;
  scale_in_t sq_d;

  logic        pv_q, rv_q;
  logic [63:0] prod_a_q, prod_b_q;
  logic        pneg_a_q, pneg_b_q, rneg_a_q, rneg_b_q;
  logic [6:0]  prsh_q;
  logic [65:0] rnd_a_d, rnd_b_d, rnd_a_q, rnd_b_q, half;

  logic        slot_v_q, phase_q;
  logic [31:0] dev_a_q, dev_b_q;

  // advance the whole pipeline unless the output slot still holds a deviate
  assign en         = !slot_v_q || (phase_q && out_o.ready);
  assign in_i.ready = en;

  pgd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .first_i  (in_i.uniform_first),
    .second_i (in_i.uniform_second),
    .valid_o  (fr_v),
    .data_o   (fr_d)
  );

  pgd_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_v),
    .data_i  (fr_d),
    .valid_o (lg_v),
    .data_o  (lg_d)
  );

  pgd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (lg_v),
    .data_i  (lg_d),
    .valid_o (dv_v),
    .data_o  (dv_d)
  );

  pgd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_v),
    .data_i  (dv_d),
    .valid_o (sq_v),
    .data_o  (sq_d)
  );

  // saturate the rounded magnitude and apply the sign
  function automatic logic [31:0] finish(input logic [65:0] r, input logic neg);
    logic [65:0] lim;
    logic [65:0] v;
    lim = neg ? (66'd1 << 31) : ((66'd1 << 31) - 66'd1);
    v   = (r > lim) ? lim : r;
    if (neg) begin
      v = 66'(~v + 66'd1);
    end
    return v[31:0];
  endfunction

  // round to nearest, ties away from zero
  always_comb begin
    half    = 66'd1 << (prsh_q - 7'd1);
    rnd_a_d = (66'(prod_a_q) + half) >> prsh_q;
    rnd_b_d = (66'(prod_b_q) + half) >> prsh_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      rv_q <= 1'b0;
    end else if (en) begin
      pv_q <= sq_v;
      rv_q <= pv_q;
    end
  end

  // scale both magnitudes by the common factor
  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_a_q <= 64'(sq_d.pair.mag1) * 64'(sq_d.s);
      prod_b_q <= 64'(sq_d.pair.mag0) * 64'(sq_d.s);
      pneg_a_q <= sq_d.pair.neg1;
      pneg_b_q <= sq_d.pair.neg0;
      prsh_q   <= sq_d.rsh;
      rnd_a_q  <= rnd_a_d;
      rnd_b_q  <= rnd_b_d;
      rneg_a_q <= pneg_a_q;
      rneg_b_q <= pneg_b_q;
    end
  end

  // output slot: hold a pair, send the v2 deviate, then the v1 deviate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_v_q <= 1'b0;
      phase_q  <= 1'b0;
    end else if (en) begin
      slot_v_q <= rv_q;
      phase_q  <= 1'b0;
    end else if (slot_v_q && out_o.ready) begin
      phase_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dev_a_q <= finish(rnd_a_q, rneg_a_q);
      dev_b_q <= finish(rnd_b_q, rneg_b_q);
    end
  end

  assign out_o.valid        = slot_v_q;
  assign out_o.deviate      = phase_q ? dev_b_q : dev_a_q;
  assign out_o.last_of_pair = phase_q;

endmodule

// File: hdl/pgd_front.sv
module pgd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     first_i,
  input  logic [31:0]     second_i,
  output logic            valid_o,
  output pgd_pkg::front_t data_o
);
  import pgd_pkg::*;

  logic [32:0] w0, w1;
  pair_t       map_d;
  pair_t       p1_q, p2_q, p3_q, p4_q;
  logic [63:0] sq0_q, sq1_q;
  logic [64:0] sum;
  logic [63:0] n3_q, n4_q;
  logic [5:0]  lz4_q;
  logic [63:0] norm;
  logic        v1_q, v2_q, v3_q, v4_q, v5_q;
  front_t      out_q;

  // map k to a sign and magnitude of 2k+1-2^B
  always_comb begin
    w0 = {first_i, 1'b1};
    w1 = {second_i, 1'b1};
    map_d.mag0 = w0[32] ? w0[31:0] : 32'(~w0[31:0] + 32'd1);
    map_d.neg0 = ~w0[32];
    map_d.mag1 = w1[32] ? w1[31:0] : 32'(~w1[31:0] + 32'd1);
    map_d.neg1 = ~w1[32];
  end

  assign sum  = {1'b0, sq0_q} + {1'b0, sq1_q};
  assign norm = n4_q << lz4_q;

  // advance valid bits; drop pairs outside the unit circle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q && !sum[64] && (sum[63:0] != 64'd0);
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // square, sum, count leading zeros, normalize
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q       <= map_d;
      p2_q       <= p1_q;
      sq0_q      <= 64'(p1_q.mag0) * 64'(p1_q.mag0);
      sq1_q      <= 64'(p1_q.mag1) * 64'(p1_q.mag1);
      p3_q       <= p2_q;
      n3_q       <= sum[63:0];
      p4_q       <= p3_q;
      n4_q       <= n3_q;
      lz4_q      <= lzc64(n3_q);
      out_q.pair <= p4_q;
      out_q.m    <= norm[63:1];
      out_q.q    <= 7'({1'b0, lz4_q} + 7'd1);
    end
  end

  assign valid_o = v5_q;
  assign data_o  = out_q;

endmodule

// File: hdl/pgd_log2.sv
module pgd_log2 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pgd_pkg::front_t   data_i,
  output logic              valid_o,
  output pgd_pkg::quot_in_t data_o
);
  import pgd_pkg::*;

  typedef struct packed {
    front_t             side;
    logic [62:0]        x;
    logic [LogBits-1:0] r;
  } lstage_t;

  lstage_t     in_s;
  lstage_t     mid_q [LogBits];
  lstage_t     st_q  [LogBits];
  logic        mid_v_q [LogBits];
  logic        st_v_q  [LogBits];
  logic [61:0] hh_q [LogBits];
  logic [62:0] hl_q [LogBits];
  logic [63:0] ll_q [LogBits];

  always_comb begin
    in_s.side = data_i;
    in_s.x    = data_i.m;
    in_s.r    = '0;
  end

  // one result bit per iteration: square in partial products, then sum and test
  for (genvar i = 0; i < LogBits; i++) begin : g_iter
    lstage_t      src;
    logic         src_v;
    logic [125:0] sq;
    logic [63:0]  pw;
    lstage_t      nxt;

    if (i == 0) begin : g_first
      assign src   = in_s;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = st_q[i-1];
      assign src_v = st_v_q[i-1];
    end

    always_comb begin
      sq = (126'(hh_q[i]) << 64) + (126'(hl_q[i]) << 33) + 126'(ll_q[i]);
      pw = sq[125:62];
      nxt = mid_q[i];
      nxt.x = pw[63] ? pw[63:1] : pw[62:0];
      nxt.r = {mid_q[i].r[LogBits-2:0], pw[63]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mid_v_q[i] <= 1'b0;
        st_v_q[i]  <= 1'b0;
      end else if (en_i) begin
        mid_v_q[i] <= src_v;
        st_v_q[i]  <= mid_v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mid_q[i] <= src;
        hh_q[i]  <= 62'(src.x[62:32]) * 62'(src.x[62:32]);
        hl_q[i]  <= 63'(src.x[62:32]) * 63'(src.x[31:0]);
        ll_q[i]  <= 64'(src.x[31:0]) * 64'(src.x[31:0]);
        st_q[i]  <= nxt;
      end
    end
  end

  // tail: T = q - log2(m), scale by 2 ln 2, normalize
  front_t       t1_q, t2_q, t3_q, t4_q;
  logic [62:0]  t_q;
  logic [61:0]  phh_q;
  logic [62:0]  phl_q, plh_q;
  logic [63:0]  pll_q;
  logic [125:0] tprod;
  logic [63:0]  qv3_q, qv4_q;
  logic [5:0]   lz4_q;
  logic [63:0]  qnorm;
  logic         tv1_q, tv2_q, tv3_q, tv4_q, tv5_q;
  quot_in_t     out_q;

  assign tprod = (126'(phh_q) << 64) + (126'(phl_q) << 32) + (126'(plh_q) << 32)
               + 126'(pll_q);
  assign qnorm = qv4_q << lz4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv1_q <= 1'b0;
      tv2_q <= 1'b0;
      tv3_q <= 1'b0;
      tv4_q <= 1'b0;
      tv5_q <= 1'b0;
    end else if (en_i) begin
      tv1_q <= st_v_q[LogBits-1];
      tv2_q <= tv1_q;
      tv3_q <= tv2_q;
      tv4_q <= tv3_q;
      tv5_q <= tv4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q      <= st_q[LogBits-1].side;
      t_q       <= (63'(st_q[LogBits-1].side.q) << LogBits)
                 - 63'(st_q[LogBits-1].r);
      t2_q      <= t1_q;
      phh_q     <= 62'(t_q[62:32]) * 62'(TwoLn2Q62[62:32]);
      phl_q     <= 63'(t_q[62:32]) * 63'(TwoLn2Q62[31:0]);
      plh_q     <= 63'(t_q[31:0]) * 63'(TwoLn2Q62[62:32]);
      pll_q     <= 64'(t_q[31:0]) * 64'(TwoLn2Q62[31:0]);
      t3_q      <= t2_q;
      qv3_q     <= tprod[125:62];
      t4_q      <= t3_q;
      qv4_q     <= qv3_q;
      lz4_q     <= lzc64(qv3_q);
      out_q.pair <= t4_q.pair;
      out_q.m    <= t4_q.m;
      out_q.qm   <= qnorm[63:1];
      out_q.e    <= 8'(63 - int'(lz4_q) + int'(t4_q.q) - LogBits);
    end
  end

  assign valid_o = tv5_q;
  assign data_o  = out_q;

endmodule

// File: hdl/pgd_div.sv
module pgd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  pgd_pkg::quot_in_t data_i,
  output logic              valid_o,
  output pgd_pkg::root_in_t data_o
);
  import pgd_pkg::*;

  typedef struct packed {
    pair_t             pair;
    logic [62:0]       m;
    logic [62:0]       rem;
    logic [62:0]       res;
    logic signed [7:0] e;
  } dstage_t;

  dstage_t st_q [DivSteps+1];
  logic    v_q  [DivSteps+1];
  dstage_t first_d;
  logic    ge0;

  // leading quotient bit
  always_comb begin
    ge0          = data_i.qm >= data_i.m;
    first_d.pair = data_i.pair;
    first_d.m    = data_i.m;
    first_d.e    = data_i.e;
    first_d.res  = 63'(ge0);
    first_d.rem  = ge0 ? 63'(data_i.qm - data_i.m) : data_i.qm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= first_d;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [63:0] rem2;
    logic        ge;
    dstage_t     nxt;

    always_comb begin
      rem2    = {st_q[i].rem, 1'b0};
      ge      = rem2 >= {1'b0, st_q[i].m};
      nxt     = st_q[i];
      nxt.rem = ge ? 63'(rem2 - {1'b0, st_q[i].m}) : rem2[62:0];
      nxt.res = {st_q[i].res[61:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i+1] <= nxt;
      end
    end
  end

  assign valid_o     = v_q[DivSteps];
  assign data_o.pair = st_q[DivSteps].pair;
  assign data_o.r    = st_q[DivSteps].res;
  assign data_o.e    = st_q[DivSteps].e;

endmodule

// File: hdl/pgd_sqrt.sv
module pgd_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  pgd_pkg::root_in_t  data_i,
  output logic               valid_o,
  output pgd_pkg::scale_in_t data_o
);
  import pgd_pkg::*;

  typedef struct packed {
    pair_t             pair;
    logic [63:0]       op;
    logic [63:0]       res;
    logic signed [7:0] e;
  } sstage_t;

  sstage_t st_q [SqrtSteps+1];
  logic    v_q  [SqrtSteps+1];
  sstage_t first_d;

  // make the exponent even, doubling the radicand when it is odd
  always_comb begin
    first_d.pair = data_i.pair;
    first_d.op   = data_i.e[0] ? {data_i.r, 1'b0} : {1'b0, data_i.r};
    first_d.e    = data_i.e[0] ? 8'(data_i.e - 8'sd1) : data_i.e;
    first_d.res  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= first_d;
    end
  end

  // digit-by-digit square root, one result bit per stage
  for (genvar i = 0; i < SqrtSteps; i++) begin : g_step
    localparam logic [63:0] One = 64'd1 << (62 - 2 * i);
    logic [64:0] trial;
    sstage_t     nxt;

    always_comb begin
      trial = {1'b0, st_q[i].res} + {1'b0, One};
      nxt   = st_q[i];
      if ({1'b0, st_q[i].op} >= trial) begin
        nxt.op  = 64'(st_q[i].op - trial[63:0]);
        nxt.res = 64'((st_q[i].res >> 1) + One);
      end else begin
        nxt.res = st_q[i].res >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i+1] <= nxt;
      end
    end
  end

  assign valid_o     = v_q[SqrtSteps];
  assign data_o.pair = st_q[SqrtSteps].pair;
  assign data_o.s    = st_q[SqrtSteps].res[31:0];
  assign data_o.rsh  = 7'(ShiftBias - (int'(st_q[SqrtSteps].e) >>> 1));

endmodule

// File: tb/tb_polar_gaussian_deviate.sv
`timescale 1ns / 100ps
module tb_polar_gaussian_deviate;
  import pgd_pkg::*;

  typedef struct {
    logic signed [OutBits-1:0] deviate;
    logic                      last_of_pair;
  } deviate_t;

  // Holds the deviates that accepted pairs must produce, and checks them in order.
  class deviate_board;
    deviate_t pending[$];
    int       errors;

    // Take the magnitude and sign of 2k+1-2^B.
    function automatic void centered(input logic [31:0] k, output logic [31:0] mag,
                                     output logic neg);
      logic [32:0] w;
      w = {k, 1'b1};
      neg = ~w[32];
      mag = w[32] ? w[31:0] : 32'(33'h1_0000_0000 - w);
    endfunction

    // Round magnitude*root to the output scale and apply the sign.
    function automatic logic [31:0] scaled(input logic [31:0] mag, input logic [63:0] root,
                                           input int sh, input logic neg);
      logic [127:0] prod;
      logic [127:0] v;
      logic [127:0] lim;
      prod = 128'(mag) * 128'(root);
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (sh >= 0) v = (prod == 0) ? 0 : ((sh >= 32 || prod > (lim >> sh)) ? lim : prod << sh);
      else begin
        v = (prod + (128'd1 << (-sh - 1))) >> (-sh);
        if (v > lim) v = lim;
      end
      if (neg) v = -v;
      return v[31:0];
    endfunction

    // Predict the deviate pair of one uniform pair; a rejected pair adds nothing.
    function void note_pair(input logic [31:0] k1, input logic [31:0] k2);
      logic [31:0]  mag1, mag2;
      logic         neg1, neg2;
      logic [127:0] nsq, sq;
      logic [63:0]  m, x, lg, t, qv, qm, r, rem, root, op, one;
      int           p, q, b, e, sh;
      deviate_t     d;
      centered(k1, mag1, neg1);
      centered(k2, mag2, neg2);
      nsq = 128'(mag1) * mag1 + 128'(mag2) * mag2;
      if (nsq == 0 || nsq >= (128'd1 << 64)) return;
      p = 0;
      for (int i = 0; i < 128; i++) if (nsq[i]) p = i;
      m = (p >= 62) ? 64'(nsq >> (p - 62)) : 64'(nsq << (62 - p));
      q = 64 - p;
      x = m;
      lg = 0;
      for (int i = 0; i < LogBits; i++) begin
        sq = (128'(x) * x) >> 62;
        lg = lg << 1;
        if (sq[63]) begin
          sq = sq >> 1;
          lg[0] = 1'b1;
        end
        x = sq[63:0];
      end
      t = (64'(q) << LogBits) - lg;
      sq = (128'(t) * 128'(TwoLn2Q62)) >> 62;
      qv = sq[63:0];
      b = 0;
      for (int i = 0; i < 64; i++) if (qv[i]) b = i;
      qm = (b <= 62) ? (qv << (62 - b)) : (qv >> 1);
      r = (qm >= m) ? 1 : 0;
      rem = qm - ((qm >= m) ? m : 0);
      for (int i = 0; i < DivSteps; i++) begin
        rem = rem << 1;
        r = r << 1;
        if (rem >= m) begin
          rem = rem - m;
          r[0] = 1'b1;
        end
      end
      e = b + q - LogBits;
      if (e % 2 != 0) begin
        r = r << 1;
        e = e - 1;
      end
      op = r;
      root = 0;
      one = 64'd1 << 62;
      for (int i = 0; i < SqrtSteps; i++) begin
        if (op >= root + one) begin
          op = op - (root + one);
          root = (root >> 1) + one;
        end else begin
          root = root >> 1;
        end
        one = one >> 2;
      end
      sh = e / 2 - ShiftBias;
      d.deviate = scaled(mag2, root, sh, neg2);
      d.last_of_pair = 1'b0;
      pending.push_back(d);
      d.deviate = scaled(mag1, root, sh, neg1);
      d.last_of_pair = 1'b1;
      pending.push_back(d);
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Compare one output transfer with the oldest prediction.
    task check_deviate(input logic signed [31:0] dev, input logic lst);
      deviate_t d;
      if (pending.size() == 0) begin
        report($sformatf("unexpected deviate %0d last %0b", dev, lst));
        return;
      end
      d = pending.pop_front();
      if (dev !== d.deviate)
        report($sformatf("deviate %0d, predicted %0d", dev, d.deviate));
      if (lst !== d.last_of_pair)
        report($sformatf("last_of_pair %0b, predicted %0b", lst, d.last_of_pair));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycle = 0;
  bit   calm = 1'b0;
  bit   done = 1'b0;
  deviate_board board = new();

  pgd_in_if  in_i ();
  pgd_out_if out_o ();

  polar_gaussian_deviate u_dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_i), .out_o(out_o));

  always #1 clk_i = ~clk_i;

  initial begin
    in_i.valid = 1'b0;
    in_i.uniform_first = '0;
    in_i.uniform_second = '0;
    out_o.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Stall the output side at random, except during the calm stretch.
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (rst_ni) out_o.ready <= calm || ($urandom_range(99) >= 16);
  end

  // Check every output transfer.
  always @(posedge clk_i) begin
    if (rst_ni && out_o.valid && out_o.ready)
      board.check_deviate(out_o.deviate, out_o.last_of_pair);
  end

  // Drive one pair and hold it until the transfer.
  task automatic send_pair(input logic [31:0] k1, input logic [31:0] k2);
    while (!calm && $urandom_range(99) < 16) begin
      in_i.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_i.valid <= 1'b1;
    in_i.uniform_first <= k1;
    in_i.uniform_second <= k2;
    do @(posedge clk_i); while (!in_i.ready);
    board.note_pair(k1, k2);
  endtask

  // Pick a sample near the center, near the edges, or anywhere.
  function automatic logic [31:0] sample();
    case ($urandom_range(3))
      0: return 32'h8000_0000 + $urandom_range(4095) - 2048;
      1: return $urandom_range(1) ? $urandom_range(65535) : 32'hFFFF_FFFF - $urandom_range(65535);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    static logic [31:0] edges[6] = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                     32'h4000_0000, 32'hB504_F333};
    @(posedge clk_i iff rst_ni);
    // Directed: extremes, center, and pairs on both sides of the unit circle.
    foreach (edges[i]) foreach (edges[j]) if (i < 4 || j < 4) send_pair(edges[i], edges[j]);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA);
    for (int n = 0; n < 1150; n++) begin
      calm = (n >= 500 && n < 650);
      send_pair(sample(), sample());
    end
    calm = 1'b0;
    in_i.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    done = 1'b1;
  end

  initial begin
    wait (done || cycle >= 200000);
    if (done && board.errors == 0 && board.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/pgd_pkg.sv
hdl/pgd_if.sv
hdl/pgd_front.sv
hdl/pgd_log2.sv
hdl/pgd_div.sv
hdl/pgd_sqrt.sv
hdl/polar_gaussian_deviate.sv
tb/tb_polar_gaussian_deviate.sv
